@@ rtl/sliding_window_distinct_detector_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window distinct detector
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_DISTINCT_DETECTOR_MACROS_SVH
`define SLIDING_WINDOW_DISTINCT_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge out of reset.
`define SWDD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define SWDD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);
`else
`define SWDD_ASSERT_ALWAYS(lbl, cond, msg)
`define SWDD_ASSERT_NEXT(lbl, trig, cond, msg)
`endif

`endif

@@ rtl/swdd_pkg.sv @@
// ----------------------------------------------------------------------------
// swdd_pkg
// Shared widths and constants for the sliding window distinct detector.
// ----------------------------------------------------------------------------
package swdd_pkg;

  // Default longest window the tap line supports.
  localparam int WINDOW_MAX_DEF = 16;
  // Window length after reset (clamped to the window maximum).
  localparam int LENGTH_RESET   = 14;

  // The alphabet is the full byte, so a symbol needs no reduction.
  localparam int SYMBOL_W    = 8;
  localparam int CFG_LEN_W   = 5;
  localparam int POS_W       = 32;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = POS_W + 3;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

endpackage

@@ rtl/sliding_window_distinct_detector.sv @@
// ----------------------------------------------------------------------------
// sliding_window_distinct_detector
// Flags positions where the most recent window_length bytes are all distinct.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  -------   ---  -----------------  ---------------------------------------
//  in_*      in   tvalid / tready    tdata: symbol; tuser: start_new
//  out_*     out  tvalid / tready    tdata: position, window_full,
//                                           all_distinct, first_marker
//  cfg_*     in   wen (no wait)      wdata: window_length
//
//  One request per cycle while in_tready is high. Each request is evaluated in
//  the cycle it is taken and its result is loaded into the output register at
//  the next edge. The output register is the only stage, so in_tready drops
//  only while a result sits unclaimed and out_tready is low.
//  Reset (rst_n low, synchronous) restores window_length to its reset value
//  and clears the window; there is no clearing pass.
//
//  Method: instead of a count per byte value, keep the age of the most recent
//  repeat, i.e. how many bytes back the newer half of the latest duplicate
//  pair's older occurrence sits. A new byte is compared against the last
//  WINDOW_MAX-1 bytes in a tap line; the nearest hit gives its repeat
//  distance, and the age becomes the smaller of (old age + 1) and that
//  distance, saturating at WINDOW_MAX. The last L bytes are distinct exactly
//  when that age is at least L.
// ----------------------------------------------------------------------------
`include "sliding_window_distinct_detector_macros.svh"

module sliding_window_distinct_detector #(
  parameter int WINDOW_MAX = swdd_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wen,
  input  logic [swdd_pkg::CFG_LEN_W-1:0]    cfg_wdata,   // [4:0] window_length
  // request stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [swdd_pkg::IN_TDATA_W-1:0]   in_tdata,    // [7:0] symbol
  input  logic                              in_tuser,    // [0] start_new
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [swdd_pkg::OUT_TDATA_W-1:0]  out_tdata    // [31:0] position,
                                                         // [32] window_full,
                                                         // [33] all_distinct,
                                                         // [34] first_marker,
                                                         // rest zero
);

  import swdd_pkg::*;

  localparam int AGE_W   = $clog2(WINDOW_MAX + 1);
  localparam int TAPS    = WINDOW_MAX - 1;
  localparam int LEN_RST = (LENGTH_RESET > WINDOW_MAX) ? WINDOW_MAX : LENGTH_RESET;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WINDOW_MAX);

  // Window state
  logic [AGE_W-1:0]    len_r;
  logic [SYMBOL_W-1:0] tap_r    [TAPS];
  logic [TAPS-1:0]     tap_vld_r, tap_vld_nxt;
  logic [AGE_W-1:0]    age_r, age_nxt;
  logic [POS_W-1:0]    cnt_r, cnt_nxt;
  logic                marker_seen_r, marker_seen_nxt;

  // Result register
  logic                out_vld_r;
  logic [POS_W-1:0]    out_pos_r;
  logic                out_full_r, out_dist_r, out_first_r;

  logic                in_acc;
  logic [SYMBOL_W-1:0] sym;
  logic [TAPS-1:0]     vld_base;
  logic [AGE_W-1:0]    age_base, age_inc, rep_dist;
  logic [POS_W-1:0]    cnt_base;
  logic                full_nxt, dist_nxt, first_nxt;
  logic [AGE_W-1:0]    cfg_len;

  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign sym       = in_tdata[SYMBOL_W-1:0];

  // Clamp the written length into 1..WINDOW_MAX.
  always_comb begin
    if (32'(cfg_wdata) > WINDOW_MAX) begin
      cfg_len = AGE_MAX;
    end else if (cfg_wdata == '0) begin
      cfg_len = AGE_W'(1);
    end else begin
      cfg_len = AGE_W'(cfg_wdata);
    end
  end

  // Evaluate one request against the window.
  always_comb begin
    // restart drops the old window before this byte goes in
    vld_base = in_tuser ? '0 : tap_vld_r;
    age_base = in_tuser ? AGE_MAX : age_r;
    cnt_base = in_tuser ? '0 : cnt_r;

    // nearest earlier copy of this byte; none within reach counts as far away
    rep_dist = AGE_MAX;
    for (int i = TAPS - 1; i >= 0; i--) begin
      if (vld_base[i] && (tap_r[i] == sym)) begin
        rep_dist = AGE_W'(i + 1);
      end
    end

    age_inc = (age_base == AGE_MAX) ? AGE_MAX : age_base + AGE_W'(1);
    age_nxt = (rep_dist < age_inc) ? rep_dist : age_inc;

    cnt_nxt = (cnt_base == POS_MAX) ? POS_MAX : cnt_base + POS_W'(1);

    full_nxt  = cnt_nxt >= POS_W'(len_r);
    dist_nxt  = full_nxt && (age_nxt >= len_r);
    first_nxt = dist_nxt && !(marker_seen_r && !in_tuser);

    marker_seen_nxt = (marker_seen_r && !in_tuser) || dist_nxt;
    // shift in a valid bit; the oldest one drops off the top
    tap_vld_nxt     = TAPS'({vld_base, 1'b1});
  end

  // Window state: a length write clears it just as a restart does.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r         <= AGE_W'(LEN_RST);
      tap_vld_r     <= '0;
      age_r         <= AGE_MAX;
      cnt_r         <= '0;
      marker_seen_r <= 1'b0;
    end else if (cfg_wen) begin
      len_r         <= cfg_len;
      tap_vld_r     <= '0;
      age_r         <= AGE_MAX;
      cnt_r         <= '0;
      marker_seen_r <= 1'b0;
    end else if (in_acc) begin
      tap_vld_r     <= tap_vld_nxt;
      age_r         <= age_nxt;
      cnt_r         <= cnt_nxt;
      marker_seen_r <= marker_seen_nxt;
    end
  end

  // Tap line of recent bytes; payload only, the valid bits guard it.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tap_r[0] <= sym;
      for (int i = 1; i < TAPS; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  // Result register: load on accept, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_tready) begin
      out_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_pos_r   <= cnt_nxt;
      out_full_r  <= full_nxt;
      out_dist_r  <= dist_nxt;
      out_first_r <= first_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_first_r, out_dist_r, out_full_r, out_pos_r};

  // Checks
  `SWDD_ASSERT_ALWAYS(a_first_is_distinct,
    !out_vld_r || !out_first_r || out_dist_r, "first_marker without all_distinct")
  `SWDD_ASSERT_ALWAYS(a_distinct_is_full,
    !out_vld_r || !out_dist_r || out_full_r, "all_distinct on a window that is not full")
  `SWDD_ASSERT_NEXT(a_restart_pos_one, in_acc && in_tuser && !cfg_wen,
    out_pos_r == POS_W'(1), "restart did not give position one")
  `SWDD_ASSERT_NEXT(a_marker_kept, in_acc && dist_nxt && !cfg_wen,
    marker_seen_r, "marker not recorded after a distinct window")
  `SWDD_ASSERT_ALWAYS(a_len_range,
    (len_r != '0) && (len_r <= AGE_MAX), "window length out of range")

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Sliding window distinct detector testbench
// Streams bytes through the detector under random valid and ready stalls.
// A scoreboard keeps its own copy of the window, the per-value counts and the
// marker flag, and checks every result word field by field. The run steps
// through several window lengths, including zero and values above the
// maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic [swdd_pkg::OUT_PAD_W-1:0] pad;
  logic                           first_marker;
  logic                           all_distinct;
  logic                           window_full;
  logic [swdd_pkg::POS_W-1:0]     position;
} distinct_result_t;

class distinct_window_tracker;
  bit [swdd_pkg::CFG_LEN_W-1:0] len_reg;
  bit [swdd_pkg::SYMBOL_W-1:0]  ring [swdd_pkg::WINDOW_MAX_DEF];
  int unsigned                  ring_wr;
  int unsigned                  hits [256];
  int unsigned                  dup_values;
  bit [swdd_pkg::POS_W-1:0]     taken;
  bit                           marker_flag;
  distinct_result_t             pending_results [$];
  int unsigned                  fail_count;

  function new();
    len_reg    = swdd_pkg::LENGTH_RESET[swdd_pkg::CFG_LEN_W-1:0];
    fail_count = 0;
    restart_window();
  endfunction

  function void restart_window();
    foreach (ring[i]) ring[i] = '0;
    foreach (hits[i]) hits[i] = 0;
    ring_wr     = 0;
    dup_values  = 0;
    taken       = '0;
    marker_flag = 1'b0;
  endfunction

  // Zero acts as one, anything past the window maximum acts as that maximum.
  function int unsigned span();
    if (len_reg == 0) return 1;
    if (len_reg > swdd_pkg::WINDOW_MAX_DEF) return swdd_pkg::WINDOW_MAX_DEF;
    return len_reg;
  endfunction

  function void load_length(bit [swdd_pkg::CFG_LEN_W-1:0] len);
    len_reg = len;
    restart_window();
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  function void note_request(bit [swdd_pkg::SYMBOL_W-1:0] sym, bit restart);
    int unsigned      width;
    int unsigned      old_slot;
    bit [7:0]         old_sym;
    distinct_result_t res;
    width = span();
    if (restart) restart_window();
    // Retire the byte that falls out of the window.
    if (taken >= width) begin
      old_slot = (ring_wr + swdd_pkg::WINDOW_MAX_DEF - width) % swdd_pkg::WINDOW_MAX_DEF;
      old_sym  = ring[old_slot];
      if (hits[old_sym] == 2 && dup_values > 0) dup_values--;
      if (hits[old_sym] > 0) hits[old_sym]--;
    end
    ring[ring_wr] = sym;
    ring_wr = (ring_wr + 1) % swdd_pkg::WINDOW_MAX_DEF;
    if (hits[sym] < 255) hits[sym]++;
    if (hits[sym] == 2) dup_values++;
    if (taken != swdd_pkg::POS_MAX) taken++;
    res              = '0;
    res.position     = taken;
    res.window_full  = (taken >= width);
    res.all_distinct = res.window_full && (dup_values == 0);
    res.first_marker = res.all_distinct && !marker_flag;
    if (res.all_distinct) marker_flag = 1'b1;
    pending_results = {pending_results, res};
  endfunction

  function void check_result(logic [swdd_pkg::OUT_TDATA_W-1:0] word);
    distinct_result_t got;
    distinct_result_t want;
    got = word;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected: %h", word);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      fail_count++;
    end
    if (got.window_full !== want.window_full) begin
      $error("window_full: expected %0b, got %0b", want.window_full, got.window_full);
      fail_count++;
    end
    if (got.all_distinct !== want.all_distinct) begin
      $error("all_distinct: expected %0b, got %0b", want.all_distinct, got.all_distinct);
      fail_count++;
    end
    if (got.first_marker !== want.first_marker) begin
      $error("first_marker: expected %0b, got %0b", want.first_marker, got.first_marker);
      fail_count++;
    end
    if (got.pad !== want.pad) begin
      $error("pad: expected %0h, got %0h", want.pad, got.pad);
      fail_count++;
    end
  endfunction

  function void flag_leftovers();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
  endfunction
endclass

module testbench;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             cfg_wen   = 1'b0;
  logic [swdd_pkg::CFG_LEN_W-1:0]   cfg_wdata = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [swdd_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;   // [7:0] symbol
  logic                             in_tuser  = 1'b0; // [0] start_new
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [swdd_pkg::OUT_TDATA_W-1:0] out_tdata;        // [31:0] position, [32] window_full,
                                                      // [33] all_distinct, [34] first_marker

  // Turn off stalls on both sides while set.
  bit no_stall = 1'b0;

  distinct_window_tracker book = new();

  sliding_window_distinct_detector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Result side: check on the edge's handshake, then pick the next ready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_result(out_tdata);
    out_tready <= no_stall ? 1'b1 : ($urandom_range(99) >= 35);
  end

  // Offer one request, idling in front of it at random; hold it until taken.
  task automatic send_symbol(input bit [7:0] sym, input bit restart);
    while (!no_stall && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 1'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    book.note_request(sym, restart);
  endtask

  // Wait for every result, then let the output stage settle.
  task automatic wait_drained();
    while (book.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_length(input bit [swdd_pkg::CFG_LEN_W-1:0] len);
    cfg_wen   <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    book.load_length(len);
  endtask

  // Mostly runs of fresh bytes so full windows come out distinct now and then;
  // sprinkle in repeats from inside the window and occasional restarts.
  task automatic run_random_phase(input int unsigned count);
    bit [7:0]    recent [$];
    bit [7:0]    sym;
    bit          restart;
    bit          clash;
    int unsigned width;
    width = book.span();
    repeat (count) begin
      restart = ($urandom_range(99) < 3);
      if (restart) recent.delete();
      if (recent.size() != 0 && $urandom_range(99) < 15) begin
        sym = recent[$urandom_range(recent.size() - 1)];
      end else begin
        do begin
          sym   = 8'($urandom_range(255));
          clash = 1'b0;
          foreach (recent[i]) if (recent[i] == sym) clash = 1'b1;
        end while (clash);
      end
      recent = {recent, sym};
      while (recent.size() > width - 1) void'(recent.pop_front());
      send_symbol(sym, restart);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    bit [swdd_pkg::CFG_LEN_W-1:0] lengths [10];
    lengths = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd9, 5'd5, 5'd14, 5'd3};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset length of 14: fill with distinct bytes, both extremes included,
    // so the marker lands on the fourteenth request.
    for (int i = 0; i < 13; i++) send_symbol(8'(i), 1'b0);
    send_symbol(8'd255, 1'b0);
    // Slide on with distinct bytes: no second marker.
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd128, 1'b0);
    // Repeat inside the window, then restart and repeat at once.
    send_symbol(8'd5, 1'b0);
    send_symbol(8'd5, 1'b1);
    send_symbol(8'd5, 1'b0);
    in_tvalid <= 1'b0;

    foreach (lengths[p]) begin
      wait_drained();
      write_length(lengths[p]);
      // Run one phase at full rate on both sides.
      no_stall = (p == 6);
      run_random_phase(110);
    end
    no_stall = 1'b0;

    for (int i = 0; i < 2000 && book.pending() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    book.flag_leftovers();
    if (book.fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop for a hung handshake.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
